>>> design/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

	localparam int OUT_BITS = 40;

	typedef struct packed {
		logic status;
		logic is_complex;
	} qrs_flags_t;

endpackage

>>> design/qrs_sqrt.sv
// Pipelined restoring square root, one root bit per stage.
module qrs_sqrt #(
	parameter int RW = 33,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   in_rad,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [RW-1:0]     out_root,
	output logic [SW-1:0]     out_side
);

	localparam int RADW = 2 * RW;
	localparam int RMW  = RW + 2;

	logic            v_s    [RW+1];
	logic [RADW-1:0] rad_s  [RW+1];
	logic [RMW-1:0]  rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [SW-1:0]   side_s [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= in_rad;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RMW-1:0] rem_sh;
		logic [RMW-1:0] trial;
		logic           ge;

		assign rem_sh = {rem_s[k][RW-1:0], rad_s[k][RADW-1 -: 2]};
		assign trial  = {root_s[k], 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_s[k] << 2;
				rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

>>> design/qrs_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module qrs_div #(
	parameter int MW  = 35,
	parameter int DVW = 17,
	parameter int SW  = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [MW-1:0]   in_num,
	input  logic [DVW-1:0]  in_den,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [MW-1:0]   out_quo,
	output logic [SW-1:0]   out_side
);

	logic           v_s    [MW+1];
	logic [MW-1:0]  qn_s   [MW+1];
	logic [DVW-1:0] rem_s  [MW+1];
	logic [DVW-1:0] dv_s   [MW+1];
	logic [SW-1:0]  side_s [MW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qn_s[0]   <= in_num;
			rem_s[0]  <= '0;
			dv_s[0]   <= in_den;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < MW; k++) begin : g_step
		logic [DVW:0] rem_sh;
		logic [DVW:0] dv_x;
		logic [DVW:0] rem_n;
		logic         ge;

		assign rem_sh = {rem_s[k], qn_s[k][MW-1]};
		assign dv_x   = {1'b0, dv_s[k]};
		assign ge     = (rem_sh >= dv_x);
		assign rem_n  = ge ? (rem_sh - dv_x) : rem_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qn_s[k+1]   <= {qn_s[k][MW-2:0], ge};
				rem_s[k+1]  <= rem_n[DVW-1:0];
				dv_s[k+1]   <= dv_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[MW];
	assign out_quo   = qn_s[MW];
	assign out_side  = side_s[MW];

endmodule

>>> design/quadratic_root_solver.sv
// Top level of the quadratic root solver: operand stages, square root, dividers, output.
// Takes one coefficient transaction per cycle and returns one result transaction per
// cycle when in_stall and out_stall are low. RW = (2*COEFF_BITS+2)/2 + FRAC_BITS
// is the square root pipeline depth (one root bit per stage) and MW is the numerator
// width of the two dividers (one quotient bit per stage). An output register and a skid
// register follow the dividers, so a stalled output halts the pipeline only once both
// are full. Roots are signed fixed point with FRAC_BITS fraction bits, rounded toward
// zero and saturated to 40 bits; a zero coefficient a gives status 1 and zero values.
module quadratic_root_solver #(
	parameter int COEFF_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COEFF_BITS-1:0]        coef_a,
	input  logic signed [COEFF_BITS-1:0]        coef_b,
	input  logic signed [COEFF_BITS-1:0]        coef_c,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                status,
	output logic                                is_complex,
	output logic signed [qrs_pkg::OUT_BITS-1:0] first_value,
	output logic signed [qrs_pkg::OUT_BITS-1:0] second_value
);

	localparam int CB   = COEFF_BITS;
	localparam int F    = FRAC_BITS;
	localparam int OB   = qrs_pkg::OUT_BITS;
	localparam int PW   = 2 * CB;
	localparam int DW   = PW + 2;
	localparam int MAGW = PW + 1;
	localparam int RW   = (MAGW + 1) / 2 + F;
	localparam int NBW  = CB + F + 1;
	localparam int DNW  = CB + 1;
	localparam int NW   = ((NBW > RW + 1) ? NBW : RW + 1) + 1;
	localparam int MW   = NW;
	localparam int DVW  = CB + 1;
	localparam int EW   = ((MW > OB) ? MW : OB) + 1;
	localparam int SQS  = $bits(qrs_pkg::qrs_flags_t) + NBW + DNW;
	localparam int D1S  = $bits(qrs_pkg::qrs_flags_t) + 1;

	localparam logic [EW-1:0] SAT_HI  = (EW'(1) << (OB - 1)) - EW'(1);
	localparam logic [OB-1:0] OUT_MIN = OB'(1) << (OB - 1);
	localparam logic [OB-1:0] OUT_MAX = ~OUT_MIN;

	logic en;
	logic skid_full_q;

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	// operand stage
	logic                 v_s1;
	logic signed [CB-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= coef_a;
			b_s1 <= coef_b;
			c_s1 <= coef_c;
		end
	end

	// products
	logic                  v_s2;
	logic signed [PW-1:0]  bb_s2, ac_s2;
	logic signed [NBW-1:0] nb_s2;
	logic signed [DNW-1:0] den_s2;
	logic                  azero_s2;
	logic signed [CB:0]    nb0;

	assign nb0 = -$signed({b_s1[CB-1], b_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2    <= b_s1 * b_s1;
			ac_s2    <= a_s1 * c_s1;
			nb_s2    <= NBW'(nb0) <<< F;
			den_s2   <= $signed({a_s1, 1'b0});
			azero_s2 <= (a_s1 == '0);
		end
	end

	// discriminant
	logic                  v_s3;
	logic signed [DW-1:0]  d_s3;
	logic signed [NBW-1:0] nb_s3;
	logic signed [DNW-1:0] den_s3;
	logic                  azero_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3     <= $signed({{2{bb_s2[PW-1]}}, bb_s2}) - $signed({ac_s2, 2'b00});
			nb_s3    <= nb_s2;
			den_s3   <= den_s2;
			azero_s3 <= azero_s2;
		end
	end

	// square root
	logic [DW-1:0]         d_abs;
	logic [2*RW-1:0]       rad;
	qrs_pkg::qrs_flags_t   flags_s3;
	logic [SQS-1:0]        sq_side_in, sq_side_out;
	logic                  sq_valid;
	logic [RW-1:0]         sq_root;

	assign d_abs               = d_s3[DW-1] ? DW'(-d_s3) : DW'(d_s3);
	assign rad                 = (2*RW)'(d_abs[MAGW-1:0]) << (2 * F);
	assign flags_s3.status     = azero_s3;
	assign flags_s3.is_complex = d_s3[DW-1];
	assign sq_side_in          = {flags_s3, nb_s3, den_s3};

	qrs_sqrt #(
		.RW (RW),
		.SW (SQS)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_rad    (rad),
		.in_side   (sq_side_in),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side_out)
	);

	// numerators
	qrs_pkg::qrs_flags_t   sq_flags;
	logic signed [NBW-1:0] sq_nb;
	logic signed [DNW-1:0] sq_den;
	logic signed [NW-1:0]  root_x, nb_x;

	assign {sq_flags, sq_nb, sq_den} = sq_side_out;
	assign root_x = $signed(NW'(sq_root));
	assign nb_x   = NW'(sq_nb);

	logic                  v_s4;
	qrs_pkg::qrs_flags_t   flags_s4;
	logic signed [NW-1:0]  n1_s4, n2_s4;
	logic signed [DNW-1:0] den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s4 <= sq_flags;
			n1_s4    <= sq_flags.is_complex ? nb_x : (nb_x + root_x);
			n2_s4    <= sq_flags.is_complex ? root_x : (nb_x - root_x);
			den_s4   <= sq_den;
		end
	end

	// dividers
	logic [MW-1:0]  n1_abs, n2_abs;
	logic [DVW-1:0] den_abs;
	logic           neg1, neg2;
	logic [D1S-1:0] d1_side_in, d1_side_out;
	logic           d1_valid, d2_valid;
	logic [MW-1:0]  q1, q2;
	logic           q2_neg;

	assign n1_abs     = n1_s4[NW-1] ? MW'(-n1_s4) : MW'(n1_s4);
	assign n2_abs     = n2_s4[NW-1] ? MW'(-n2_s4) : MW'(n2_s4);
	assign den_abs    = den_s4[DNW-1] ? DVW'(-den_s4) : DVW'(den_s4);
	assign neg1       = n1_s4[NW-1] ^ den_s4[DNW-1];
	assign neg2       = n2_s4[NW-1] ^ den_s4[DNW-1];
	assign d1_side_in = {flags_s4, neg1};

	qrs_div #(
		.MW  (MW),
		.DVW (DVW),
		.SW  (D1S)
	) u_div_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num    (n1_abs),
		.in_den    (den_abs),
		.in_side   (d1_side_in),
		.out_valid (d1_valid),
		.out_quo   (q1),
		.out_side  (d1_side_out)
	);

	qrs_div #(
		.MW  (MW),
		.DVW (DVW),
		.SW  (1)
	) u_div_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num    (n2_abs),
		.in_den    (den_abs),
		.in_side   (neg2),
		.out_valid (d2_valid),
		.out_quo   (q2),
		.out_side  (q2_neg)
	);

	// sign, saturate, select
	qrs_pkg::qrs_flags_t fin_flags;
	logic                q1_neg;
	logic [EW-1:0]       q1_x, q2_x;
	logic [OB-1:0]       v1, v2;
	logic                p_status, p_complex;
	logic [OB-1:0]       p_first, p_second;

	assign {fin_flags, q1_neg} = d1_side_out;
	assign q1_x = EW'(q1);
	assign q2_x = EW'(q2);

	always_comb begin
		if (q1_neg) begin
			v1 = (q1_x > SAT_HI + EW'(1)) ? OUT_MIN : OB'(EW'(0) - q1_x);
		end else begin
			v1 = (q1_x > SAT_HI) ? OUT_MAX : OB'(q1_x);
		end
		if (q2_neg) begin
			v2 = (q2_x > SAT_HI + EW'(1)) ? OUT_MIN : OB'(EW'(0) - q2_x);
		end else begin
			v2 = (q2_x > SAT_HI) ? OUT_MAX : OB'(q2_x);
		end
	end

	assign p_status  = fin_flags.status;
	assign p_complex = fin_flags.is_complex && !fin_flags.status;
	assign p_first   = fin_flags.status ? '0 : v1;
	assign p_second  = fin_flags.status ? '0 : v2;

	// output register and skid
	logic          out_ready;
	logic          sk_status_q, sk_complex_q;
	logic [OB-1:0] sk_first_q, sk_second_q;
	logic          out_valid_q;

	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ready) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end
		end else if (d1_valid && d2_valid) begin
			if (out_ready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_ready) begin
				status       <= sk_status_q;
				is_complex   <= sk_complex_q;
				first_value  <= sk_first_q;
				second_value <= sk_second_q;
			end
		end else if (d1_valid && d2_valid) begin
			if (out_ready) begin
				status       <= p_status;
				is_complex   <= p_complex;
				first_value  <= p_first;
				second_value <= p_second;
			end else begin
				sk_status_q  <= p_status;
				sk_complex_q <= p_complex;
				sk_first_q   <= p_first;
				sk_second_q  <= p_second;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> verif/quadratic_root_solver_tb.sv
// Self-checking testbench for the quadratic root solver: random and corner coefficient streams.
module quadratic_root_solver_tb;

	localparam int CB = 16;
	localparam int FB = 16;
	localparam int SQRT_PAIRS = 26;
	localparam int LATENCY = 80;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [CB-1:0] a;
		logic signed [CB-1:0] b;
		logic signed [CB-1:0] c;
	} coef_set_t;

	typedef struct {
		logic                                status;
		logic                                is_complex;
		logic signed [qrs_pkg::OUT_BITS-1:0] first_value;
		logic signed [qrs_pkg::OUT_BITS-1:0] second_value;
	} root_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CB-1:0] coef_a = '0, coef_b = '0, coef_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status, is_complex;
	logic signed [qrs_pkg::OUT_BITS-1:0] first_value, second_value;

	coef_set_t pending_sets[$];
	root_set_t expected_roots[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 1'b0;
	bit drain_hold = 1'b0;
	int long_hold = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit all_queued = 1'b0;

	quadratic_root_solver #(.COEFF_BITS(CB), .FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .is_complex(is_complex),
		.first_value(first_value), .second_value(second_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor(sqrt(r * 4^FB)) without forming the scaled radicand
	function automatic logic [63:0] int_sqrt(input logic [63:0] r);
		logic [63:0] root, rem, trial, pair;
		root = 0;
		rem = 0;
		for (int i = SQRT_PAIRS + FB - 1; i >= 0; i--) begin
			pair = (i >= FB) ? ((r >> (2 * (i - FB))) & 64'd3) : 64'd0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic signed [qrs_pkg::OUT_BITS-1:0] clamp40(input longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (qrs_pkg::OUT_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[qrs_pkg::OUT_BITS-1:0];
	endfunction

	function automatic root_set_t solve_roots(input coef_set_t cs);
		root_set_t r;
		longint a, b, c, d, den, nb, s;
		a = cs.a;
		b = cs.b;
		c = cs.c;
		r = '{1'b1, 1'b0, '0, '0};
		if (a == 0) return r;
		d = b * b - 4 * a * c;
		den = 2 * a;
		nb = -b * (64'sd1 <<< FB);
		r.status = 1'b0;
		if (d < 0) begin
			s = int_sqrt(-d);
			r.is_complex = 1'b1;
			r.first_value = clamp40(nb / den);
			r.second_value = clamp40(s / den);
		end else begin
			s = int_sqrt(d);
			r.is_complex = 1'b0;
			r.first_value = clamp40((nb + s) / den);
			r.second_value = clamp40((nb - s) / den);
		end
		return r;
	endfunction

	function automatic logic [CB-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return CB'($urandom_range(0, 7) - 3);
			3: return CB'($urandom_range(0, 255) - 128);
			default: return CB'($urandom());
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("quadratic_root_solver verification failed");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid) expected_roots.push_back(solve_roots('{coef_a, coef_b, coef_c}));
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (drain_hold && expected_roots.size() + in_valid != 0) begin
				in_valid <= 1'b0;
			end else if (pending_sets.size() != 0) begin
				coef_set_t cs;
				if (drain_hold) drain_hold <= 1'b0;
				cs = pending_sets.pop_front();
				in_valid <= 1'b1;
				coef_a <= cs.a;
				coef_b <= cs.b;
				coef_c <= cs.c;
				if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_roots.size() == 0) begin
					$display("%0t: unexpected transaction: %b %b %h %h", $time,
						status, is_complex, first_value, second_value);
					errors <= errors + 1;
				end else begin
					root_set_t e;
					e = expected_roots.pop_front();
					if (e.status !== status || e.is_complex !== is_complex ||
					    e.first_value !== first_value || e.second_value !== second_value) begin
						$display("%0t: mismatch expected %b %b %h %h actual %b %b %h %h", $time,
							e.status, e.is_complex, e.first_value, e.second_value,
							status, is_complex, first_value, second_value);
						errors <= errors + 1;
					end
				end
			end
			if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 5);
			end
		end
	end

	initial begin
		logic [CB-1:0] ext[4];
		ext = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
		foreach (ext[i])
			foreach (ext[j]) pending_sets.push_back('{ext[i], ext[j], ext[(i + j) % 4]});
		pending_sets.push_back('{16'd1, -16'sd2, 16'd1});
		pending_sets.push_back('{16'd1, 16'd0, 16'd1});
		pending_sets.push_back('{-16'sd1, 16'd0, -16'sd1});
		pending_sets.push_back('{16'd1, -16'sd3, 16'd2});
		pending_sets.push_back('{16'd2, 16'd1, 16'd0});
		pending_sets.push_back('{-16'sd3, 16'd5, 16'd7});
		pending_sets.push_back('{16'h8000, 16'h8000, 16'h7FFF});
		pending_sets.push_back('{16'h7FFF, 16'h0000, 16'h7FFF});
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int k = 0; k < 2000; k++)
			pending_sets.push_back('{pick_coef(), pick_coef(), pick_coef()});
		repeat (300) @(posedge clk);
		long_hold <= 200;
		while (pending_sets.size() > 1500) @(posedge clk);
		drain_hold <= 1'b1;
		while (pending_sets.size() > 300) @(posedge clk);
		calm <= 1'b1;
		while (pending_sets.size() != 0 || in_valid) @(posedge clk);
		while (expected_roots.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0)
			$display("quadratic_root_solver verification clean");
		else
			$display("quadratic_root_solver verification failed");
		$finish;
	end

endmodule

>>> sim.f
design/qrs_pkg.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver.sv
verif/quadratic_root_solver_tb.sv
